// ===== hw/rtl/cfnc_pkg.sv =====
// shared types and constants of the call frequency top-n classifier
// no dependencies; used by cfnc_ctrl, cfnc_dp and the top level

package cfnc_pkg;

  localparam int unsigned TOKEN_W   = 6;
  localparam int unsigned TOPN_W    = 7;
  localparam int unsigned OUT_CNT_W = 32;
  localparam int unsigned S_DATA_W  = 8;
  localparam int unsigned M_DATA_W  = 72;
  localparam int unsigned APB_AW    = 3;
  localparam int unsigned APB_DW    = 32;

  localparam logic [TOPN_W-1:0] TOPN_RESET = 7'd2;

  // register index taken from paddr[2]
  localparam logic REG_TOP_N = 1'b0;

  // item kinds
  localparam logic KIND_LOG   = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MINE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic in_ready;   // input beat may be taken
    logic clr_wr;     // clearing pass: zero entry at index
    logic latch_in;   // input beat taken: latch fields, read own counter
    logic take_mine;  // own counter on read data: update or keep it
    logic scan_rd;    // read entry at index during scan
    logic out_load;   // load output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic tok_valid;  // latched token below table depth
    logic is_query;   // latched kind is a query
    logic idx_last;   // index on last table entry
    logic out_free;   // output register may take a result
  } stat_t;

endpackage

// ===== hw/rtl/cfnc_ctrl.sv =====
// controller state machine of the call frequency top-n classifier
// depends on cfnc_pkg (state_e, cmd_t, stat_t)

module cfnc_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  cfnc_pkg::stat_t stat_i,
  output cfnc_pkg::cmd_t  cmd_o
);

  cfnc_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cfnc_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      cfnc_pkg::ST_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (stat_i.idx_last) begin
          state_d = cfnc_pkg::ST_IDLE;
        end
      end
      cfnc_pkg::ST_IDLE: begin
        cmd_o.in_ready = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch_in = 1'b1;
          state_d        = cfnc_pkg::ST_MINE;
        end
      end
      cfnc_pkg::ST_MINE: begin
        cmd_o.take_mine = 1'b1;
        if (stat_i.tok_valid && stat_i.is_query) begin
          state_d = cfnc_pkg::ST_SCAN;
        end else begin
          state_d = cfnc_pkg::ST_DONE;
        end
      end
      cfnc_pkg::ST_SCAN: begin
        cmd_o.scan_rd = 1'b1;
        if (stat_i.idx_last) begin
          state_d = cfnc_pkg::ST_DRAIN;
        end
      end
      cfnc_pkg::ST_DRAIN: begin
        state_d = cfnc_pkg::ST_DONE;
      end
      cfnc_pkg::ST_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = cfnc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = cfnc_pkg::ST_CLEAR;
      end
    endcase
  end

endmodule

// ===== hw/rtl/cfnc_dp.sv =====
// datapath of the call frequency top-n classifier: counter memory, total,
// scan compare and count, output register; depends on cfnc_pkg

module cfnc_dp #(
  parameter int unsigned NUM_TOKENS  = 64,
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  cfnc_pkg::cmd_t                  cmd_i,
  output cfnc_pkg::stat_t                 stat_o,
  input  logic                            kind_i,
  input  logic [cfnc_pkg::TOKEN_W-1:0]    tok_i,
  input  logic [cfnc_pkg::TOPN_W-1:0]     top_n_i,
  input  logic                            out_ready_i,
  output logic                            out_valid_o,
  output logic [cfnc_pkg::M_DATA_W-1:0]   out_data_o
);

  localparam int unsigned AW = $clog2(NUM_TOKENS);
  localparam int unsigned LW = $clog2(NUM_TOKENS + 1);
  localparam logic [31:0] NT = 32'(NUM_TOKENS);
  localparam logic [AW-1:0] LAST_IDX = AW'(NUM_TOKENS - 1);

  logic [COUNT_WIDTH-1:0] mem [NUM_TOKENS];
  logic [COUNT_WIDTH-1:0] rdata_q;

  logic                         kind_q;
  logic [cfnc_pkg::TOKEN_W-1:0] tok_q;
  logic [AW-1:0]                idx_q;
  logic [COUNT_WIDTH-1:0]       mine_q;
  logic [COUNT_WIDTH-1:0]       cnt_q;
  logic [COUNT_WIDTH-1:0]       total_q;
  logic [LW-1:0]                larger_q;
  logic                         scan_pend_q;

  logic                           out_valid_q;
  logic                           out_hit_q;
  logic [cfnc_pkg::OUT_CNT_W-1:0] out_cnt_q;
  logic [cfnc_pkg::OUT_CNT_W-1:0] out_tot_q;

  logic                   tok_valid;
  logic                   do_log;
  logic                   rd_en;
  logic [AW-1:0]          rd_addr;
  logic                   wr_en;
  logic [AW-1:0]          wr_addr;
  logic [COUNT_WIDTH-1:0] wr_data;
  logic [COUNT_WIDTH-1:0] cnt_inc;
  logic                   hit;

  assign tok_valid = 32'(tok_q) < NT;
  assign do_log    = cmd_i.take_mine && tok_valid && (kind_q == cfnc_pkg::KIND_LOG);
  assign cnt_inc   = rdata_q + COUNT_WIDTH'(1);

  // one read port: own counter on entry, index during scan
  assign rd_en   = cmd_i.latch_in || cmd_i.scan_rd;
  assign rd_addr = cmd_i.latch_in ? AW'(tok_i) : idx_q;

  // one write port: clearing pass or log update
  assign wr_en   = cmd_i.clr_wr || do_log;
  assign wr_addr = cmd_i.clr_wr ? idx_q : AW'(tok_q);
  assign wr_data = cmd_i.clr_wr ? '0 : cnt_inc;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  // fields, own count and mine
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      kind_q <= kind_i;
      tok_q  <= tok_i;
    end
    if (cmd_i.take_mine) begin
      mine_q <= rdata_q;
      if (!tok_valid) begin
        cnt_q <= '0;
      end else if (kind_q == cfnc_pkg::KIND_LOG) begin
        cnt_q <= cnt_inc;
      end else begin
        cnt_q <= rdata_q;
      end
    end
  end

  // index, total, scan count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      total_q     <= '0;
      larger_q    <= '0;
      scan_pend_q <= 1'b0;
    end else begin
      scan_pend_q <= cmd_i.scan_rd;
      if (cmd_i.latch_in) begin
        idx_q <= '0;
      end else if (cmd_i.clr_wr || cmd_i.scan_rd) begin
        idx_q <= idx_q + AW'(1);
      end
      if (do_log) begin
        total_q <= total_q + COUNT_WIDTH'(1);
      end
      if (cmd_i.take_mine) begin
        larger_q <= '0;
      end else if (scan_pend_q && (rdata_q > mine_q)) begin
        larger_q <= larger_q + LW'(1);
      end
    end
  end

  // in the top group when fewer than top_n counts are strictly larger
  assign hit = (kind_q == cfnc_pkg::KIND_QUERY) && tok_valid && (top_n_i != '0) &&
               (32'(larger_q) < 32'(top_n_i));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_hit_q <= hit;
      out_cnt_q <= cfnc_pkg::OUT_CNT_W'(cnt_q);
      out_tot_q <= cfnc_pkg::OUT_CNT_W'(total_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = {7'd0, out_tot_q, out_cnt_q, out_hit_q};

  assign stat_o.tok_valid = tok_valid;
  assign stat_o.is_query  = (kind_q == cfnc_pkg::KIND_QUERY);
  assign stat_o.idx_last  = (idx_q == LAST_IDX);
  assign stat_o.out_free  = !out_valid_q || out_ready_i;

endmodule

// ===== hw/rtl/call_frequency_top_n_classifier.sv =====
// top level of the call frequency top-n classifier: stream ports, apb
// register top_n; depends on cfnc_pkg, cfnc_ctrl and cfnc_dp
//
//  channel   dir     handshake                  payload
//  s_axis    in      s_axis_tvalid/tready       tdata: token, tuser: kind
//  m_axis    out     m_axis_tvalid/tready       tdata: in_top, token_count, total_calls
//  apb       in      psel/penable, pready = 1   top_n at byte address 0
//
// a log beat passes from accept to result load through accept with own-counter
// read, update and output load; a query beat adds a scan of the counter memory
// through its single read port, one entry a cycle, and a drain step before the load
// after reset a clearing pass zeroes every entry of the counter memory,
// with s_axis_tready low; apb writes are taken during it
// one item is in work at a time; the output register lets the next beat be
// taken while a result waits, and a finished result stalls in its last step
// until the output register is free

module call_frequency_top_n_classifier #(
  parameter int unsigned NUM_TOKENS  = 64,
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [cfnc_pkg::S_DATA_W-1:0] s_axis_tdata,  // [5:0] token, [7:6] zero
  input  logic [0:0]                    s_axis_tuser,  // [0] kind
  // output stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [0] in_top, [32:1] token_count, [64:33] total_calls, [71:65] zero
  output logic [cfnc_pkg::M_DATA_W-1:0] m_axis_tdata,
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [cfnc_pkg::APB_AW-1:0]   paddr,
  input  logic [cfnc_pkg::APB_DW-1:0]   pwdata,
  output logic [cfnc_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);

  cfnc_pkg::cmd_t  cmd;
  cfnc_pkg::stat_t stat;

  logic [cfnc_pkg::TOPN_W-1:0] top_n_q;
  logic                        reg_wr;

  // apb register: written in the access phase, no wait states
  assign pready = 1'b1;
  assign reg_wr = psel && penable && pwrite && (paddr[2] == cfnc_pkg::REG_TOP_N);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_n_q <= cfnc_pkg::TOPN_RESET;
    end else if (reg_wr) begin
      top_n_q <= pwdata[cfnc_pkg::TOPN_W-1:0];
    end
  end

  // only one register; other addresses read zero
  assign prdata = (paddr[2] == cfnc_pkg::REG_TOP_N) ? cfnc_pkg::APB_DW'(top_n_q) : '0;

  assign s_axis_tready = cmd.in_ready;

  cfnc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  cfnc_dp #(
    .NUM_TOKENS  (NUM_TOKENS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .kind_i      (s_axis_tuser[0]),
    .tok_i       (s_axis_tdata[cfnc_pkg::TOKEN_W-1:0]),
    .top_n_i     (top_n_q),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata)
  );

endmodule
